[rtl/core/lzwd_pkg.sv]
package lzwd_pkg;

  // Window geometry: 4096 bytes addressed by 12-bit absolute positions.
  localparam int unsigned WIN_AW    = 12;
  localparam int unsigned WIN_DEPTH = 1 << WIN_AW;
  localparam int unsigned FILL_W    = WIN_AW + 1;

  // A match copies at most 18 + 255 bytes.
  localparam int unsigned LEN_W = 9;

  // Request codes of the input channel.
  localparam logic [1:0] REQ_DATA  = 2'd0;
  localparam logic [1:0] REQ_START = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;

  // What a compressed byte asks of the output side.
  localparam logic [1:0] TOK_NONE  = 2'd0;
  localparam logic [1:0] TOK_LIT   = 2'd1;
  localparam logic [1:0] TOK_COPY  = 2'd2;

  typedef struct packed {
    logic [1:0]        kind;
    logic [7:0]        lit;
    logic [WIN_AW-1:0] pos;
    logic [LEN_W-1:0]  len;
  } tok_t;

endpackage

[rtl/core/lzwd_window.sv]
module lzwd_window (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         clr,
  input  logic                         we,
  input  logic [7:0]                   wdata,
  input  logic                         re,
  input  logic [lzwd_pkg::WIN_AW-1:0]  raddr,
  output logic [7:0]                   rdata
);

  logic [7:0]                  mem [lzwd_pkg::WIN_DEPTH];
  logic [7:0]                  q_r;
  logic                        fwd_hit_r;
  logic [7:0]                  fwd_data_r;
  logic                        vld_r;
  logic [lzwd_pkg::WIN_AW-1:0] wp_r;
  logic [lzwd_pkg::WIN_AW-1:0] wp_nxt;
  logic [lzwd_pkg::FILL_W-1:0] fill_r;
  logic [lzwd_pkg::FILL_W-1:0] fill_nxt;

  // Writes always land at the write pointer, which starts at zero after a
  // clear, so the entries written so far are exactly those below the fill
  // count. Anything above it still reads as zero.
  always_comb begin
    wp_nxt   = wp_r;
    fill_nxt = fill_r;
    if (clr) begin
      wp_nxt   = '0;
      fill_nxt = '0;
    end else if (we) begin
      wp_nxt = wp_r + 1'b1;
      if (fill_r != lzwd_pkg::FILL_W'(lzwd_pkg::WIN_DEPTH)) begin
        fill_nxt = fill_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= '0;
      fill_r <= '0;
    end else begin
      wp_r   <= wp_nxt;
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wp_r] <= wdata;
    end
  end

  // A read of the entry written in the same cycle returns old data from the
  // array, so the written byte is forwarded instead.
  always_ff @(posedge clk) begin
    if (re) begin
      q_r        <= mem[raddr];
      fwd_hit_r  <= we && (raddr == wp_r);
      fwd_data_r <= wdata;
      vld_r      <= {1'b0, raddr} < fill_r;
    end
  end

  assign rdata = fwd_hit_r ? fwd_data_r : (vld_r ? q_r : 8'd0);

endmodule

[rtl/core/lzwd_token_parser.sv]
module lzwd_token_parser (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic           take,
  input  logic [7:0]     data_byte,
  output lzwd_pkg::tok_t tok
);

  localparam logic [1:0] PH_START    = 2'd0;
  localparam logic [1:0] PH_TOKEN    = 2'd1;
  localparam logic [1:0] PH_MATCH_HI = 2'd2;
  localparam logic [1:0] PH_EXTEND   = 2'd3;

  logic [15:0]                 flag_r;
  logic [15:0]                 flag_nxt;
  logic [1:0]                  phase_r;
  logic [1:0]                  phase_nxt;
  logic [7:0]                  first_r;
  logic [7:0]                  first_nxt;
  logic [lzwd_pkg::WIN_AW-1:0] pend_r;
  logic [lzwd_pkg::WIN_AW-1:0] pend_nxt;

  always_comb begin
    logic [15:0]                 fs;
    logic                        go_token;
    logic [lzwd_pkg::WIN_AW-1:0] pos;
    logic [4:0]                  len_small;

    flag_nxt  = flag_r;
    phase_nxt = phase_r;
    first_nxt = first_r;
    pend_nxt  = pend_r;
    tok       = '0;
    tok.kind  = lzwd_pkg::TOK_NONE;
    tok.lit   = data_byte;
    fs        = flag_r;
    go_token  = 1'b0;
    pos       = {data_byte[3:0], first_r};
    len_small = 5'd3 + {1'b0, data_byte[7:4]};

    case (phase_r)
      PH_START: begin
        // The flag byte is used up once the marker bit has shifted past
        // bit 8; then this byte is the next flag byte.
        fs        = {1'b0, flag_r[15:1]};
        phase_nxt = PH_TOKEN;
        if (!fs[8]) begin
          flag_nxt = {8'hff, data_byte};
        end else begin
          flag_nxt = fs;
          go_token = 1'b1;
        end
      end
      PH_TOKEN: begin
        go_token = 1'b1;
      end
      PH_MATCH_HI: begin
        if (len_small == 5'd18) begin
          pend_nxt  = pos;
          phase_nxt = PH_EXTEND;
        end else begin
          phase_nxt = PH_START;
          tok.kind  = lzwd_pkg::TOK_COPY;
          tok.pos   = pos;
          tok.len   = lzwd_pkg::LEN_W'(len_small);
        end
      end
      default: begin
        phase_nxt = PH_START;
        tok.kind  = lzwd_pkg::TOK_COPY;
        tok.pos   = pend_r;
        tok.len   = lzwd_pkg::LEN_W'(18) + {1'b0, data_byte};
      end
    endcase

    if (go_token) begin
      if (fs[0]) begin
        first_nxt = data_byte;
        phase_nxt = PH_MATCH_HI;
      end else begin
        phase_nxt = PH_START;
        tok.kind  = lzwd_pkg::TOK_LIT;
      end
    end

    if (!take) begin
      flag_nxt  = flag_r;
      phase_nxt = phase_r;
      first_nxt = first_r;
      pend_nxt  = pend_r;
    end
    if (start) begin
      flag_nxt  = '0;
      phase_nxt = PH_START;
      first_nxt = '0;
      pend_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flag_r  <= '0;
      phase_r <= PH_START;
      first_r <= '0;
      pend_r  <= '0;
    end else begin
      flag_r  <= flag_nxt;
      phase_r <= phase_nxt;
      first_r <= first_nxt;
      pend_r  <= pend_nxt;
    end
  end

endmodule

[rtl/core/lzss_window_decompressor.sv]
// LZSS decoder with a 4096-byte history window held in one synchronous RAM.
// Items carry one compressed byte each; start and clear requests, bytes that
// only load a flag or open a match, and bytes of a stopped block leave the
// decoder idle. A literal or a match holds the input side until it ends;
// the window RAM is read once and written once per output byte, and a
// full output register that is not taken stalls the copy. Decoded
// bytes leave packed PACK_LANES to a result, and a partial pack closes every
// item that produced bytes. A clear takes effect at once: a fill count marks
// which window entries have been written since, and the rest read as zero,
// so there is no clearing pass.
module lzss_window_decompressor #(
  parameter int unsigned PACK_LANES = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_req_type,
  input  logic [7:0]  in_data_byte,
  input  logic        in_is_last,
  input  logic [31:0] in_out_limit,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_data,
  output logic [3:0]  out_count,
  output logic        out_run_last,
  output logic        out_limit_hit
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_LIT  = 2'd1;
  localparam logic [1:0] S_COPY = 2'd2;

  logic [1:0]                   state_r, state_nxt;
  logic [7:0]                   lit_r, lit_nxt;
  logic [lzwd_pkg::WIN_AW-1:0]  rd_pos_r, rd_pos_nxt;
  logic [lzwd_pkg::LEN_W-1:0]   rem_len_r, rem_len_nxt;
  logic                         q_pend_r, q_pend_nxt;
  logic                         last_r, last_nxt;
  logic [31:0]                  remaining_r, remaining_nxt;
  logic                         stopped_r, stopped_nxt;
  logic [63:0]                  pack_r, pack_nxt;
  logic [3:0]                   pack_cnt_r, pack_cnt_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [63:0]                  out_data_r, out_data_nxt;
  logic [3:0]                   out_count_r, out_count_nxt;
  logic                         out_run_last_r, out_run_last_nxt;
  logic                         out_limit_hit_r, out_limit_hit_nxt;

  logic                         accept;
  logic                         take;
  logic                         start;
  logic                         clr;
  lzwd_pkg::tok_t               tok;
  logic                         win_we;
  logic                         win_re;
  logic [7:0]                   win_rdata;

  logic                         out_free;
  logic                         adv;
  logic [7:0]                   put_byte;
  logic                         do_put;
  logic                         put_ok;
  logic                         hit;
  logic                         stop;
  logic                         end_item;
  logic [63:0]                  pack_add;
  logic [3:0]                   cnt_add;
  logic                         flush;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign start    = accept && (in_req_type == lzwd_pkg::REQ_START);
  assign clr      = accept && (in_req_type == lzwd_pkg::REQ_CLEAR);
  assign take     = accept && (in_req_type == lzwd_pkg::REQ_DATA) && !stopped_r;

  lzwd_token_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .take      (take),
    .data_byte (in_data_byte),
    .tok       (tok)
  );

  lzwd_window u_window (
    .clk   (clk),
    .rst_n (rst_n),
    .clr   (clr),
    .we    (win_we),
    .wdata (put_byte),
    .re    (win_re),
    .raddr (rd_pos_r),
    .rdata (win_rdata)
  );

  // One output byte per advancing cycle: the byte read in the previous advancing
  // cycle is emitted and written back while the next match byte is read.
  assign out_free = !out_valid_r || out_ready;
  assign adv      = (state_r != S_IDLE) && out_free;
  assign put_byte = (state_r == S_LIT) ? lit_r : win_rdata;
  assign do_put   = adv && ((state_r == S_LIT) || ((state_r == S_COPY) && q_pend_r));
  assign put_ok   = do_put && !stopped_r && (remaining_r != 32'd0);
  assign hit      = put_ok && (remaining_r == 32'd1);
  assign stop     = (do_put && !put_ok) || hit;
  assign end_item = adv && ((state_r == S_LIT) ||
                            (q_pend_r && (stop || (rem_len_r == '0))));
  assign win_we   = put_ok;
  assign win_re   = adv && (state_r == S_COPY) && (rem_len_r != '0) && !stop;

  assign pack_add = put_ok ? (pack_r | ({56'd0, put_byte} << {pack_cnt_r[2:0], 3'b000}))
                           : pack_r;
  assign cnt_add  = pack_cnt_r + {3'd0, put_ok};
  assign flush    = adv && (cnt_add != 4'd0) &&
                    (hit || (cnt_add == 4'(PACK_LANES)) || end_item);

  always_comb begin
    state_nxt         = state_r;
    lit_nxt           = lit_r;
    rd_pos_nxt        = rd_pos_r;
    rem_len_nxt       = rem_len_r;
    q_pend_nxt        = q_pend_r;
    last_nxt          = last_r;
    remaining_nxt     = remaining_r;
    stopped_nxt       = stopped_r;
    pack_nxt          = pack_r;
    pack_cnt_nxt      = pack_cnt_r;
    out_valid_nxt     = out_valid_r && !out_ready;
    out_data_nxt      = out_data_r;
    out_count_nxt     = out_count_r;
    out_run_last_nxt  = out_run_last_r;
    out_limit_hit_nxt = out_limit_hit_r;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          remaining_nxt = in_out_limit;
          stopped_nxt   = 1'b0;
        end
        if (take) begin
          lit_nxt     = tok.lit;
          rd_pos_nxt  = tok.pos;
          rem_len_nxt = tok.len;
          q_pend_nxt  = 1'b0;
          last_nxt    = in_is_last;
          case (tok.kind)
            lzwd_pkg::TOK_LIT:  state_nxt = S_LIT;
            lzwd_pkg::TOK_COPY: state_nxt = S_COPY;
            default: begin
              if (in_is_last) begin
                stopped_nxt = 1'b1;
              end
            end
          endcase
        end
      end
      S_LIT, S_COPY: begin
        if (adv) begin
          if (put_ok) begin
            remaining_nxt = remaining_r - 32'd1;
          end
          if (stop) begin
            stopped_nxt = 1'b1;
          end
          if (win_re) begin
            rd_pos_nxt  = rd_pos_r + 1'b1;
            rem_len_nxt = rem_len_r - 1'b1;
            q_pend_nxt  = 1'b1;
          end
          if (flush) begin
            out_valid_nxt     = 1'b1;
            out_data_nxt      = pack_add;
            out_count_nxt     = cnt_add;
            out_run_last_nxt  = end_item;
            out_limit_hit_nxt = hit;
            pack_nxt          = '0;
            pack_cnt_nxt      = 4'd0;
          end else begin
            pack_nxt     = pack_add;
            pack_cnt_nxt = cnt_add;
          end
          if (end_item) begin
            state_nxt  = S_IDLE;
            q_pend_nxt = 1'b0;
            if (last_r) begin
              stopped_nxt = 1'b1;
            end
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      q_pend_r    <= 1'b0;
      remaining_r <= '0;
      stopped_r   <= 1'b0;
      pack_r      <= '0;
      pack_cnt_r  <= 4'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      q_pend_r    <= q_pend_nxt;
      remaining_r <= remaining_nxt;
      stopped_r   <= stopped_nxt;
      pack_r      <= pack_nxt;
      pack_cnt_r  <= pack_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lit_r           <= lit_nxt;
    rd_pos_r        <= rd_pos_nxt;
    rem_len_r       <= rem_len_nxt;
    last_r          <= last_nxt;
    out_data_r      <= out_data_nxt;
    out_count_r     <= out_count_nxt;
    out_run_last_r  <= out_run_last_nxt;
    out_limit_hit_r <= out_limit_hit_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_data      = out_data_r;
  assign out_count     = out_count_r;
  assign out_run_last  = out_run_last_r;
  assign out_limit_hit = out_limit_hit_r;

endmodule

[rtl/core/lzwd_checker.sv]
module lzwd_checker #(
  parameter int unsigned PACK_LANES = 8
) (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [1:0]  in_req_type,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] out_data,
  input logic [3:0]  out_count,
  input logic        out_run_last,
  input logic        out_limit_hit
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data) &&
      $stable(out_count) && $stable(out_run_last) && $stable(out_limit_hit))
    else $error("stalled result changed");

  // Reaching the limit ends the item, so that result is its last.
  a_hit_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_limit_hit |-> out_run_last)
    else $error("limit hit on a result that is not the last of its item");

  // Only the closing result of an item may carry a partial pack.
  a_partial: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_count != 4'(PACK_LANES)) |-> out_run_last)
    else $error("partial pack before the end of its item");

  // Start, clear and unknown requests never occupy the decoder.
  a_ctrl_fast: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_req_type != lzwd_pkg::REQ_DATA) |=> in_ready)
    else $error("control request held the input side");

endmodule

bind lzss_window_decompressor lzwd_checker #(.PACK_LANES(PACK_LANES)) u_lzwd_checker (.*);
